[hdl/qacs_pkg.sv]
// Package with shared types, constants and the arctangent table of the angle scaler.
package qacs_pkg;

   localparam int ATAN_LEN = 24;
   localparam int ACC_W = 32;
   localparam logic [15:0] ANG_180 = 16'd23040;
   localparam logic [15:0] ANG_360 = 16'd46080;
   localparam logic signed [ACC_W-1:0] ACC_180 = 32'sd11796480;
   localparam logic signed [ACC_W-1:0] ACC_90 = 32'sd5898240;
   localparam int SCALE_TOP = 90;
   localparam int SCALED_SAT = 511;

   typedef enum logic [1:0] {
      MODE_OPEN   = 2'd0,
      MODE_CLOSED = 2'd1,
      MODE_RUN    = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ROT_CW      = 2'd0,
      ROT_CCW     = 2'd1,
      ROT_CW_WRAP = 2'd2,
      ROT_CCW_WRAP = 2'd3
   } rot_type;

   localparam logic [0:0] REG_MODE = 1'b0;
   localparam logic [0:0] REG_DEAD_BAND = 1'b1;

   // Divider handshake between the top level and the serial divider.
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;

   function automatic logic signed [ACC_W-1:0] atan_entry(input logic [4:0] idx);
      logic signed [ACC_W-1:0] v;
      case (idx)
         5'd0: v = 32'sd2949120;
         5'd1: v = 32'sd1740967;
         5'd2: v = 32'sd919879;
         5'd3: v = 32'sd466945;
         5'd4: v = 32'sd234379;
         5'd5: v = 32'sd117304;
         5'd6: v = 32'sd58666;
         5'd7: v = 32'sd29335;
         5'd8: v = 32'sd14668;
         5'd9: v = 32'sd7334;
         5'd10: v = 32'sd3667;
         5'd11: v = 32'sd1833;
         5'd12: v = 32'sd917;
         5'd13: v = 32'sd458;
         5'd14: v = 32'sd229;
         5'd15: v = 32'sd115;
         5'd16: v = 32'sd57;
         5'd17: v = 32'sd29;
         5'd18: v = 32'sd14;
         5'd19: v = 32'sd7;
         5'd20: v = 32'sd4;
         5'd21: v = 32'sd2;
         5'd22: v = 32'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[hdl/qacs_cordic.sv]
// Iterative vectoring arctangent unit, one micro-rotation per cycle.
module qacs_cordic #(
   parameter int SAMPLE_BITS = 12,
   parameter int MID_SCALE = 2048,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [SAMPLE_BITS-1:0] sine_value,
   input  logic [SAMPLE_BITS-1:0] cosine_value,
   output logic                   done,
   output logic [15:0]            angle
);
   import qacs_pkg::*;

   localparam int XW = SAMPLE_BITS + 12;
   localparam int NSTEP = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

   logic signed [XW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ACC_W-1:0] z_ff, z_in;
   logic [4:0] step_ff, step_in;
   logic busy_ff, busy_in, done_ff, done_in;

   logic signed [XW-1:0] cx, cy, dx, dy;
   logic signed [ACC_W-1:0] t;
   logic signed [ACC_W-1:0] r;

   always_comb begin
      cx = (XW'($signed({1'b0, cosine_value})) - XW'(MID_SCALE)) <<< 8;
      cy = (XW'($signed({1'b0, sine_value})) - XW'(MID_SCALE)) <<< 8;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      dx = y_ff >>> step_ff;
      dy = x_ff >>> step_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         if (cx == 0 && cy == 0) begin
            x_in = '0; y_in = '0; z_in = '0;
            step_in = 5'(NSTEP);
         end else if (cx < 0) begin
            if (cy >= 0) begin
               x_in = cy; y_in = -cx; z_in = ACC_90;
            end else begin
               x_in = -cy; y_in = cx; z_in = -ACC_90;
            end
         end else begin
            x_in = cx; y_in = cy; z_in = '0;
         end
      end else if (busy_ff) begin
         if (step_ff == 5'(NSTEP)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (y_ff >= 0) begin
               x_in = x_ff + dx; y_in = y_ff - dy; z_in = z_ff + atan_entry(step_ff);
            end else begin
               x_in = x_ff - dx; y_in = y_ff + dy; z_in = z_ff - atan_entry(step_ff);
            end
            step_in = step_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      step_ff <= step_in;
   end

   always_comb begin
      t = z_ff + ACC_180;
      if (t < 0) t = '0;
      r = (t + 32'sd256) >>> 9;
      if (r > $signed({16'd0, ANG_360})) r = $signed({16'd0, ANG_360});
   end

   assign angle = r[15:0];
   assign done = done_ff;

endmodule

[hdl/qacs_divider.sv]
// Bit-serial restoring divider for the signed span ratio, one quotient bit per cycle.
module qacs_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [23:0] numerator,
   input  logic signed [17:0] denominator,
   output qacs_pkg::div_ctl_type ctl,
   output logic signed [23:0] quotient
);
   import qacs_pkg::*;

   localparam int QW = 24;

   logic [QW-1:0] q_ff, q_in;
   logic [QW:0] rem_ff, rem_in;
   logic [17:0] d_ff, d_in;
   logic neg_ff, neg_in;
   logic [4:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [QW:0] trial;

   always_comb begin
      q_in = q_ff;
      rem_in = rem_ff;
      d_in = d_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = '0;
      if (start) begin
         q_in = numerator[QW-1] ? QW'(-numerator) : numerator;
         d_in = denominator[17] ? 18'(-denominator) : denominator;
         neg_in = numerator[QW-1] ^ denominator[17];
         rem_in = '0;
         cnt_in = 5'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff[QW-1:0], q_ff[QW-1]};
         if (trial >= (QW+1)'(d_ff)) begin
            rem_in = trial - (QW+1)'(d_ff);
            q_in = {q_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in = {q_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff <= q_in;
      rem_ff <= rem_in;
      d_ff <= d_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   assign quotient = neg_ff ? -$signed(q_ff) : $signed(q_ff);
   assign ctl.start = start;
   assign ctl.busy = busy_ff;
   assign ctl.done = done_ff;

endmodule

[hdl/quadrature_angle_calibrated_scaler_unit.sv]
// Top level of the quadrature angle scaler: calibration, dead band and scaling control.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_ready, req_sine_sample, req_cosine_sample
//   rsp     | out       | rsp_valid, rsp_ready, rsp_changed .. rsp_span_zero
//   csr     | in        | csr_write, csr_index, csr_data
//
// When no scaling is needed the response of a request is registered once the CORDIC
// micro-rotations are done, and the block is then ready for the next request. A pair
// at exact mid-scale skips the micro-rotations. In run mode, when the pair is outside
// the dead band and the span is nonzero, the serial divider is started, loads its
// operands and works out the quotient bit by bit before the response is registered.
// Reset is synchronous and active high; it restores the calibration state.
// A response waits in its output register while a new request is accepted; the
// next response is held back until the waiting one has been taken.
module quadrature_angle_calibrated_scaler_unit #(
   parameter int SAMPLE_BITS = 12,
   parameter int MID_SCALE = 2048,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sine_sample,
   input  logic [SAMPLE_BITS-1:0] req_cosine_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_changed,
   output logic signed [9:0]      rsp_scaled_angle,
   output logic [15:0]            rsp_raw_angle,
   output logic [1:0]             rsp_rotation,
   output logic                   rsp_span_zero,
   input  logic                   csr_write,
   input  logic                   csr_index,
   input  logic [11:0]            csr_data
);
   import qacs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ANGLE, ST_DECIDE, ST_DIVIDE, ST_HOLD
   } state_type;

   state_type state_ff;
   logic [1:0] mode_ff;
   logic [11:0] dead_band_ff;
   logic [SAMPLE_BITS-1:0] sine_ff, cosine_ff, last_sine_ff, last_cosine_ff;
   logic [15:0] open_ff, closed_ff, angle_ff;
   logic [1:0] dir_ff;
   logic cordic_start_ff, div_start_ff;
   logic signed [23:0] num_ff;
   logic signed [17:0] den_ff;

   // Result register.
   logic out_valid_ff, out_changed_ff, out_zero_ff;
   logic signed [9:0] out_scaled_ff;
   logic [15:0] out_raw_ff;
   logic [1:0] out_rot_ff;

   logic cordic_done;
   logic [15:0] angle;
   div_ctl_type div_ctl;
   logic signed [23:0] quotient;

   qacs_cordic #(
      .SAMPLE_BITS(SAMPLE_BITS), .MID_SCALE(MID_SCALE), .CORDIC_STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock(clock), .reset(reset), .start(cordic_start_ff),
      .sine_value(sine_ff), .cosine_value(cosine_ff),
      .done(cordic_done), .angle(angle)
   );

   qacs_divider u_div (
      .clock(clock), .reset(reset), .start(div_start_ff),
      .numerator(num_ff), .denominator(den_ff),
      .ctl(div_ctl), .quotient(quotient)
   );

   // Dead band test on one sample against its stored value.
   function automatic logic near(input logic [SAMPLE_BITS-1:0] s,
                                 input logic [SAMPLE_BITS-1:0] p,
                                 input logic [11:0] db);
      logic [17:0] sw, pw, dw;
      sw = 18'(s);
      pw = 18'(p);
      dw = 18'(db);
      return (sw < pw + dw) && (pw >= dw) && (sw > pw - dw);
   endfunction

   // Span numerator and denominator by rotation class, all in 1/128 degree.
   logic signed [18:0] an, o, cl, num_w, den_w;
   logic inside_band;
   always_comb begin
      an = 19'(angle_ff);
      o = 19'(open_ff);
      cl = 19'(closed_ff);
      num_w = '0;
      den_w = '0;
      unique case (rot_type'(dir_ff))
         ROT_CW: begin
            num_w = an - cl; den_w = o - cl;
         end
         ROT_CCW: begin
            num_w = cl - an; den_w = cl - o;
         end
         ROT_CW_WRAP: begin
            if (angle_ff < ANG_180) an = an + 19'(ANG_360);
            num_w = an - cl; den_w = o + 19'(ANG_360) - cl;
         end
         ROT_CCW_WRAP: begin
            if (angle_ff > ANG_180) an = an - 19'(ANG_360);
            num_w = cl - an; den_w = cl - (o - 19'(ANG_360));
         end
         default: ;
      endcase
      inside_band = near(sine_ff, last_sine_ff, dead_band_ff) &&
                    near(cosine_ff, last_cosine_ff, dead_band_ff);
   end

   logic signed [23:0] sat;
   always_comb begin
      sat = quotient;
      if (quotient > 24'sd511) sat = 24'sd511;
      if (quotient < -24'sd511) sat = -24'sd511;
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff <= MODE_OPEN;
         dead_band_ff <= 12'd50;
         last_sine_ff <= '0;
         last_cosine_ff <= '0;
         open_ff <= '0;
         closed_ff <= '0;
         dir_ff <= ROT_CW;
         cordic_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cordic_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         if (out_valid_ff && rsp_ready) out_valid_ff <= 1'b0;
         if (csr_write) begin
            if (csr_index == REG_MODE) mode_ff <= csr_data[1:0];
            else dead_band_ff <= csr_data;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  sine_ff <= req_sine_sample;
                  cosine_ff <= req_cosine_sample;
                  cordic_start_ff <= 1'b1;
                  state_ff <= ST_ANGLE;
               end
            end
            ST_ANGLE: begin
               if (cordic_done) begin
                  angle_ff <= angle;
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if (!out_valid_ff || rsp_ready) begin
                  out_raw_ff <= angle_ff;
                  out_changed_ff <= 1'b0;
                  out_scaled_ff <= '0;
                  out_zero_ff <= 1'b0;
                  out_rot_ff <= dir_ff;
                  state_ff <= ST_IDLE;
                  out_valid_ff <= 1'b1;
                  case (mode_type'(mode_ff))
                     MODE_OPEN: open_ff <= angle_ff;
                     MODE_CLOSED: begin
                        closed_ff <= angle_ff;
                        if (angle_ff < open_ff) begin
                           out_rot_ff <= (open_ff - angle_ff > ANG_180) ? ROT_CCW_WRAP : ROT_CW;
                           dir_ff <= (open_ff - angle_ff > ANG_180) ? ROT_CCW_WRAP : ROT_CW;
                        end else begin
                           out_rot_ff <= (angle_ff - open_ff > ANG_180) ? ROT_CW_WRAP : ROT_CCW;
                           dir_ff <= (angle_ff - open_ff > ANG_180) ? ROT_CW_WRAP : ROT_CCW;
                        end
                     end
                     MODE_RUN: begin
                        if (!inside_band) begin
                           last_sine_ff <= sine_ff;
                           last_cosine_ff <= cosine_ff;
                           out_changed_ff <= 1'b1;
                           if (den_w == 0) begin
                              out_zero_ff <= 1'b1;
                           end else begin
                              num_ff <= 24'(num_w) * 24'sd90;
                              den_ff <= 18'(den_w);
                              div_start_ff <= 1'b1;
                              out_valid_ff <= 1'b0;
                              state_ff <= ST_DIVIDE;
                           end
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_DIVIDE: begin
               if (div_ctl.done) begin
                  out_scaled_ff <= sat[9:0];
                  out_valid_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_changed = out_changed_ff;
   assign rsp_scaled_angle = out_scaled_ff;
   assign rsp_raw_angle = out_raw_ff;
   assign rsp_rotation = out_rot_ff;
   assign rsp_span_zero = out_zero_ff;

`ifndef SYNTHESIS
   a_div_only_run: assert property (@(posedge clock) disable iff (reset)
      div_start_ff |-> mode_ff == MODE_RUN) else $error("divider started outside run");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> !req_ready) else $error("request taken while dividing");
   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_span_zero |-> rsp_scaled_angle == 0 && rsp_changed)
      else $error("zero span with nonzero angle");
`endif

endmodule
